>>> sv/bss_pkg.sv
// Shared types and constants of the balance safety supervisor.
package bss_pkg;

  // Operation codes of an input item
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_START = 1'b1;

  // Safety modes
  localparam logic [1:0] MODE_DISARMED    = 2'd0;
  localparam logic [1:0] MODE_CALIBRATING = 2'd1;
  localparam logic [1:0] MODE_BALANCING   = 2'd2;
  localparam logic [1:0] MODE_FAULT       = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FALL_ANGLE        = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STILL_DELTA       = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CALIBRATION_TIME  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COMMAND_TIMEOUT   = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_UPRIGHT_ANGLE = 3'd4;

  localparam int unsigned CFG_DATA_BITS = 32;

  // Register reset values
  localparam logic [14:0] FALL_ANGLE_RESET        = 15'd3840;
  localparam logic [14:0] STILL_DELTA_RESET       = 15'd512;
  localparam logic [31:0] CALIBRATION_TIME_RESET  = 32'd1000;
  localparam logic [31:0] COMMAND_TIMEOUT_RESET   = 32'd250;
  localparam logic [14:0] MAX_UPRIGHT_ANGLE_RESET = 15'd1280;

  // Input item
  typedef struct packed {
    logic               op;
    logic [31:0]        now_ms;
    logic signed [15:0] angle;
    logic               gyro_fresh;
    logic               arm;
    logic               stop;
    logic [31:0]        command_time_ms;
    logic signed [15:0] start_angle;
  } req_t;

  // Result item
  typedef struct packed {
    logic [1:0]         mode;
    logic               motors_on;
    logic signed [15:0] upright_angle;
    logic [15:0]        calibration_range;
    logic               start_accepted;
  } rsp_t;

endpackage

>>> sv/balance_safety_supervisor.sv
// Top level of the balance safety supervisor: mode sequencer and serial divider.
//
// Usage: one input item on req (valid/ready) gives exactly one result on rsp
// (valid/ready). An item is either a sensor frame with command flags or a direct
// start request. Configuration is written on cfg_we/cfg_index/cfg_data; the
// user must write it only while the block is idle, which the block itself
// does not enforce. Unknown indexes are ignored.
// Sequence: the item steps through a command-age check and a calibration-time
// check on one shared time subtract/compare unit, then an evaluation step. When
// a calibration finishes, the average is formed by a restoring divider that
// retires one quotient bit a cycle over the 16 + COUNT_BITS bits of the sum,
// then a check step. req_ready is high only while the sequencer idles, so a
// new item is not taken until the previous one has left the sequencer.
// The result sits in an output register; the next item is accepted while it
// waits. If rsp_ready stays low, the following item completes its work and
// holds in its last step until the register drains.
// Reset: synchronous, clears the mode to disarmed and all calibration state to
// zero, and loads the register defaults. No item is in flight after reset.
module balance_safety_supervisor
  import bss_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  req_t                      req,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output rsp_t                      rsp,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int unsigned SUM_BITS      = 16 + COUNT_BITS;
  localparam int unsigned CMP_BITS      = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam int unsigned DIV_CNT_BITS  = $clog2(SUM_BITS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD,
    S_CAL,
    S_EVAL,
    S_DIV,
    S_FIN,
    S_DONE
  } state_t;

  state_t state;

  // Configuration registers
  logic [14:0] fall_angle;
  logic [14:0] still_delta;
  logic [31:0] calibration_time;
  logic [31:0] command_timeout;
  logic [14:0] max_upright_angle;

  // Supervisor state
  logic [1:0]                 mode;
  logic [TIME_BITS-1:0]       cal_start;
  logic [TIME_BITS-1:0]       arm_time;
  logic signed [15:0]         init_angle;
  logic signed [15:0]         min_angle;
  logic signed [15:0]         max_angle;
  logic signed [SUM_BITS-1:0] angle_sum;
  logic [COUNT_BITS-1:0]      sample_count;
  logic signed [15:0]         upright_ref;
  logic                       accepted;

  // Captured item and check flags
  req_t item;
  logic cmd_ok;
  logic cal_done;

  // Divider
  logic [COUNT_BITS-1:0]   div_rem;
  logic [SUM_BITS-1:0]     div_quo;
  logic [DIV_CNT_BITS-1:0] div_left;
  logic                    div_neg;

  // Time fields at the configured width
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] ctime_t;

  assign now_t   = TIME_BITS'(item.now_ms);
  assign ctime_t = TIME_BITS'(item.command_time_ms);

  // Shared time unit: elapsed time against a limit, operands chosen by step
  logic [TIME_BITS-1:0] tc_base;
  logic [TIME_BITS-1:0] tc_elapsed;
  logic [CMP_BITS-1:0]  tc_a;
  logic [CMP_BITS-1:0]  tc_b;
  logic                 tc_gt;

  always_comb begin
    if (state == S_CMD) begin
      tc_base = (mode == MODE_DISARMED) ? ctime_t : arm_time;
    end else begin
      tc_base = (mode == MODE_DISARMED) ? now_t : cal_start;
    end
    tc_elapsed = now_t - tc_base;
    if (state == S_CMD) begin
      tc_a = CMP_BITS'(tc_elapsed);
      tc_b = CMP_BITS'(command_timeout);
    end else begin
      tc_a = CMP_BITS'(calibration_time);
      tc_b = CMP_BITS'(tc_elapsed);
    end
    tc_gt = tc_a > tc_b;
  end

  // Angle magnitudes for the limit checks
  logic signed [16:0] drift_diff;
  logic signed [16:0] fall_diff;
  logic [16:0]        drift_mag;
  logic [16:0]        fall_mag;
  logic [16:0]        start_mag;
  logic               drift;

  always_comb begin
    drift_diff = {item.angle[15], item.angle} - {init_angle[15], init_angle};
    fall_diff  = {item.angle[15], item.angle} - {upright_ref[15], upright_ref};
    drift_mag  = drift_diff[16] ? 17'(-drift_diff) : 17'(drift_diff);
    fall_mag   = fall_diff[16] ? 17'(-fall_diff) : 17'(fall_diff);
    start_mag  = item.start_angle[15] ? 17'(-{1'b1, item.start_angle})
                                      : {1'b0, item.start_angle};
    drift      = drift_mag > {2'b00, still_delta};
  end

  // Mode decisions of one item
  logic [1:0]                 mode_next;
  logic [TIME_BITS-1:0]       cal_start_next;
  logic [TIME_BITS-1:0]       arm_time_next;
  logic signed [15:0]         init_angle_next;
  logic signed [15:0]         min_angle_next;
  logic signed [15:0]         max_angle_next;
  logic signed [SUM_BITS-1:0] angle_sum_next;
  logic [COUNT_BITS-1:0]      sample_count_next;
  logic signed [15:0]         upright_ref_next;
  logic                       accepted_next;
  logic                       divide_next;
  logic signed [SUM_BITS-1:0] angle_ext;
  logic [SUM_BITS-1:0]        sum_mag;

  always_comb begin
    mode_next         = mode;
    cal_start_next    = cal_start;
    arm_time_next     = arm_time;
    init_angle_next   = init_angle;
    min_angle_next    = min_angle;
    max_angle_next    = max_angle;
    angle_sum_next    = angle_sum;
    sample_count_next = sample_count;
    upright_ref_next  = upright_ref;
    accepted_next     = 1'b0;
    divide_next       = 1'b0;
    angle_ext         = SUM_BITS'(item.angle);

    if (item.op == OP_START) begin
      // Direct start: only from disarmed within the upright limit
      if (mode == MODE_DISARMED && start_mag <= {2'b00, max_upright_angle}) begin
        init_angle_next   = item.start_angle;
        min_angle_next    = item.start_angle;
        max_angle_next    = item.start_angle;
        angle_sum_next    = SUM_BITS'(item.start_angle);
        sample_count_next = COUNT_BITS'(1);
        upright_ref_next  = item.start_angle;
        mode_next         = MODE_BALANCING;
        accepted_next     = 1'b1;
      end
    end else if (item.stop) begin
      mode_next = MODE_DISARMED;
    end else begin
      case (mode)
        MODE_DISARMED: begin
          // Arm: first sample is the initial angle itself
          if (item.arm && item.gyro_fresh && cmd_ok) begin
            mode_next         = MODE_CALIBRATING;
            cal_start_next    = now_t;
            arm_time_next     = ctime_t;
            init_angle_next   = item.angle;
            min_angle_next    = item.angle;
            max_angle_next    = item.angle;
            angle_sum_next    = angle_ext;
            sample_count_next = COUNT_BITS'(1);
            divide_next       = cal_done;
          end
        end
        MODE_CALIBRATING: begin
          if (item.gyro_fresh) begin
            if (item.angle < min_angle) begin
              min_angle_next = item.angle;
            end
            if (item.angle > max_angle) begin
              max_angle_next = item.angle;
            end
            // Accumulate still samples until the count saturates
            if (!drift && !(&sample_count)) begin
              angle_sum_next    = angle_sum + angle_ext;
              sample_count_next = sample_count + COUNT_BITS'(1);
            end
          end
          if (cal_done) begin
            if (!item.gyro_fresh) begin
              mode_next = MODE_FAULT;
            end else if (!drift) begin
              if (sample_count_next == '0 || !cmd_ok) begin
                mode_next = MODE_FAULT;
              end else begin
                divide_next = 1'b1;
              end
            end
          end else if (item.gyro_fresh && drift) begin
            mode_next = MODE_FAULT;
          end
        end
        MODE_BALANCING: begin
          if (!item.gyro_fresh || fall_mag >= {2'b00, fall_angle}) begin
            mode_next = MODE_FAULT;
          end
        end
        default: begin
        end
      endcase
    end

    sum_mag = angle_sum_next[SUM_BITS-1] ? SUM_BITS'(-angle_sum_next)
                                         : SUM_BITS'(angle_sum_next);
  end

  // Divider step: one quotient bit a cycle
  logic [COUNT_BITS:0] div_shift;
  logic                div_ge;

  always_comb begin
    div_shift = {div_rem, div_quo[SUM_BITS-1]};
    div_ge    = div_shift >= {1'b0, sample_count};
  end

  assign req_ready = (state == S_IDLE);

  // Sequencer, supervisor state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      rsp_valid         <= 1'b0;
      fall_angle        <= FALL_ANGLE_RESET;
      still_delta       <= STILL_DELTA_RESET;
      calibration_time  <= CALIBRATION_TIME_RESET;
      command_timeout   <= COMMAND_TIMEOUT_RESET;
      max_upright_angle <= MAX_UPRIGHT_ANGLE_RESET;
      mode              <= MODE_DISARMED;
      cal_start         <= '0;
      arm_time          <= '0;
      init_angle        <= '0;
      min_angle         <= '0;
      max_angle         <= '0;
      angle_sum         <= '0;
      sample_count      <= '0;
      upright_ref       <= '0;
      accepted          <= 1'b0;
    end else begin
      // Configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FALL_ANGLE:        fall_angle        <= cfg_data[14:0];
          REG_STILL_DELTA:       still_delta       <= cfg_data[14:0];
          REG_CALIBRATION_TIME:  calibration_time  <= cfg_data[31:0];
          REG_COMMAND_TIMEOUT:   command_timeout   <= cfg_data[31:0];
          REG_MAX_UPRIGHT_ANGLE: max_upright_angle <= cfg_data[14:0];
          default: begin
          end
        endcase
      end

      // Drop the result once taken, unless the next one replaces it now
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            item  <= req;
            state <= S_CMD;
          end
        end
        S_CMD: begin
          cmd_ok <= !tc_gt;
          state  <= S_CAL;
        end
        S_CAL: begin
          cal_done <= !tc_gt;
          state    <= S_EVAL;
        end
        S_EVAL: begin
          mode         <= mode_next;
          cal_start    <= cal_start_next;
          arm_time     <= arm_time_next;
          init_angle   <= init_angle_next;
          min_angle    <= min_angle_next;
          max_angle    <= max_angle_next;
          angle_sum    <= angle_sum_next;
          sample_count <= sample_count_next;
          upright_ref  <= upright_ref_next;
          accepted     <= accepted_next;
          div_rem      <= '0;
          div_quo      <= sum_mag;
          div_neg      <= angle_sum_next[SUM_BITS-1];
          div_left     <= DIV_CNT_BITS'(SUM_BITS);
          state        <= divide_next ? S_DIV : S_DONE;
        end
        S_DIV: begin
          div_rem  <= div_ge ? COUNT_BITS'(div_shift - {1'b0, sample_count})
                             : div_shift[COUNT_BITS-1:0];
          div_quo  <= {div_quo[SUM_BITS-2:0], div_ge};
          div_left <= div_left - DIV_CNT_BITS'(1);
          if (div_left == DIV_CNT_BITS'(1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // Check the average magnitude against the upright limit
          if (div_quo > SUM_BITS'(max_upright_angle)) begin
            mode <= MODE_FAULT;
          end else begin
            upright_ref <= div_neg ? -div_quo[15:0] : div_quo[15:0];
            mode        <= MODE_BALANCING;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          // Hold until the output register is free
          if (!rsp_valid || rsp_ready) begin
            rsp_valid             <= 1'b1;
            rsp.mode              <= mode;
            rsp.motors_on         <= (mode == MODE_BALANCING);
            rsp.upright_angle     <= upright_ref;
            rsp.calibration_range <= max_angle - min_angle;
            rsp.start_accepted    <= accepted;
            state                 <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A fault holds unless a stop frame arrives
  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL && mode == MODE_FAULT && !(item.op == OP_FRAME && item.stop))
    |=> mode == MODE_FAULT)
    else $error("fault mode left without a stop");

  // The divider never runs with an empty sample count
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> sample_count != '0)
    else $error("division started with zero samples");

  // An accepted start request always reports balancing
  a_start_balancing: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.start_accepted) |-> rsp.mode == MODE_BALANCING)
    else $error("accepted start without balancing mode");

  // An accepted item enters the sequencer on the next cycle
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> state == S_CMD)
    else $error("accepted item did not start the sequence");

endmodule
